// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/lbps_pkg.sv =====
// Shared types, codes and pattern ROM for the LED blink pattern sequencer.
package lbps_pkg;

  localparam int ChannelsDefault = 3;
  localparam int RomChannels     = 3;
  localparam int TimeW           = 12;
  localparam int ModeW           = 3;
  localparam int ClientW         = 2;
  localparam int StatW           = 2;
  localparam int InDataW         = 8;
  localparam int OutDataW        = 8;

  localparam logic [TimeW-1:0] ResetPeriod = 12'd500;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  localparam logic [StatW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatW-1:0] STAT_BAD_CLI  = 2'd1;
  localparam logic [StatW-1:0] STAT_BAD_MODE = 2'd2;

  localparam logic [ClientW-1:0] CLI_POWER   = 2'd0;
  localparam logic [ClientW-1:0] CLI_NETWORK = 2'd1;
  localparam logic [ClientW-1:0] CLI_STATUS  = 2'd2;

  typedef struct packed {
    logic             tick;
    logic             load;
    logic [ModeW-1:0] mode;
  } ctrl_t;

  function automatic logic [ModeW-1:0] mode_count(input logic [ClientW-1:0] ch);
    logic [ModeW-1:0] n;
    case (ch)
      CLI_POWER:   n = 3'd3;
      CLI_NETWORK: n = 3'd6;
      CLI_STATUS:  n = 3'd3;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic two_steps(input logic [ClientW-1:0] ch,
                                     input logic [ModeW-1:0] mode);
    logic r;
    case (ch)
      CLI_POWER:   r = (mode == 3'd2);
      CLI_NETWORK: r = (mode inside {[3'd1:3'd4]});
      CLI_STATUS:  r = (mode == 3'd2);
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic step_level(input logic [ClientW-1:0] ch,
                                      input logic [ModeW-1:0] mode,
                                      input logic phase);
    logic r;
    case (ch)
      CLI_POWER: begin
        case (mode)
          3'd1:    r = 1'b1;
          3'd2:    r = ~phase;
          default: r = 1'b0;
        endcase
      end
      CLI_NETWORK: begin
        case (mode)
          3'd1, 3'd2, 3'd3, 3'd4: r = ~phase;
          3'd5:                   r = 1'b1;
          default:                r = 1'b0;
        endcase
      end
      CLI_STATUS: begin
        case (mode)
          3'd1:    r = 1'b1;
          3'd2:    r = ~phase;
          default: r = 1'b0;
        endcase
      end
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [TimeW-1:0] step_period(input logic [ClientW-1:0] ch,
                                                   input logic [ModeW-1:0] mode,
                                                   input logic phase);
    logic [TimeW-1:0] p;
    p = 12'd500;
    if (!phase) begin
      if (ch == CLI_NETWORK) begin
        case (mode)
          3'd3, 3'd5: p = 12'd1000;
          3'd4:       p = 12'd1500;
          default:    p = 12'd500;
        endcase
      end
    end else begin
      case (ch)
        CLI_POWER:   p = (mode == 3'd2) ? 12'd2500 : 12'd500;
        CLI_NETWORK: begin
          case (mode)
            3'd2, 3'd4: p = 12'd2500;
            3'd3:       p = 12'd2000;
            3'd5:       p = 12'd1000;
            default:    p = 12'd500;
          endcase
        end
        default: p = 12'd500;
      endcase
    end
    return p;
  endfunction

endpackage

// ===== src/lbps_channel.sv =====
// One LED channel: mode, step phase and millisecond countdown.
module lbps_channel #(
  parameter int ChId = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lbps_pkg::ctrl_t ctrl_i,
  output logic            level_d_o
);

  localparam logic [lbps_pkg::ClientW-1:0] Ch = lbps_pkg::ClientW'(ChId);

  logic [lbps_pkg::ModeW-1:0] mode_q, mode_d;
  logic                       phase_q, phase_d;
  logic [lbps_pkg::TimeW-1:0] time_q, time_d;
  logic                       nxt;

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    time_d  = time_q;
    nxt     = ~phase_q & lbps_pkg::two_steps(Ch, mode_q);
    if (ctrl_i.load) begin
      mode_d  = ctrl_i.mode;
      phase_d = 1'b0;
      time_d  = lbps_pkg::step_period(Ch, ctrl_i.mode, 1'b0);
    end else if (ctrl_i.tick) begin
      if (time_q <= lbps_pkg::TimeW'(1)) begin
        phase_d = nxt;
        time_d  = lbps_pkg::step_period(Ch, mode_q, nxt);
      end else begin
        time_d = time_q - lbps_pkg::TimeW'(1);
      end
    end
  end

  assign level_d_o = lbps_pkg::step_level(Ch, mode_d, phase_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      phase_q <= 1'b0;
      time_q  <= lbps_pkg::ResetPeriod;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      time_q  <= time_d;
    end
  end

endmodule

// ===== src/led_blink_pattern_sequencer_core.sv =====
// Top level of the LED blink pattern sequencer.
// Each input beat is held in the input register, then its result beat in the result register.
// Throughput: one beat per cycle; input register, channel update and result
// register form a two-stage pipeline that stalls only on m_axis_tready.
// Reset: all channels return to mode 0, first step, 500 ms left; no beat held.
module led_blink_pattern_sequencer_core #(
  parameter int CHANNELS = lbps_pkg::ChannelsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lbps_pkg::InDataW-1:0]  s_axis_tdata,  // client[1:0], mode_sel[4:2]
  input  logic                          s_axis_tuser,  // func[0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lbps_pkg::OutDataW-1:0] m_axis_tdata   // led_power[0], led_network[1],
                                                       // led_status[2], status[4:3]
);

  localparam int Active = (CHANNELS > lbps_pkg::RomChannels) ? lbps_pkg::RomChannels
                                                             : CHANNELS;

  logic                          in_valid_q;
  logic                          func_q;
  logic [lbps_pkg::ClientW-1:0]  client_q;
  logic [lbps_pkg::ModeW-1:0]    mode_q;
  logic                          out_valid_q;
  logic [lbps_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                          advance;
  logic                          cli_ok, mode_ok, set_ok;
  logic [lbps_pkg::StatW-1:0]    stat;
  logic [lbps_pkg::RomChannels-1:0] level_d;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign cli_ok  = (int'(client_q) < Active);
  assign mode_ok = (mode_q < lbps_pkg::mode_count(client_q));
  assign set_ok  = (func_q == lbps_pkg::FUNC_SET) & cli_ok & mode_ok;

  always_comb begin
    if (func_q == lbps_pkg::FUNC_TICK) begin
      stat = lbps_pkg::STAT_OK;
    end else if (!cli_ok) begin
      stat = lbps_pkg::STAT_BAD_CLI;
    end else if (!mode_ok) begin
      stat = lbps_pkg::STAT_BAD_MODE;
    end else begin
      stat = lbps_pkg::STAT_OK;
    end
  end

  for (genvar ch = 0; ch < lbps_pkg::RomChannels; ch++) begin : g_ch
    if (ch < Active) begin : g_on
      lbps_pkg::ctrl_t ctrl;
      assign ctrl.tick = advance & (func_q == lbps_pkg::FUNC_TICK);
      assign ctrl.load = advance & set_ok & (client_q == lbps_pkg::ClientW'(ch));
      assign ctrl.mode = mode_q;

      lbps_channel #(
        .ChId(ch)
      ) u_channel (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .level_d_o(level_d[ch])
      );
    end else begin : g_off
      assign level_d[ch] = 1'b0;
    end
  end

  assign out_data_d = {3'b000, stat, level_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      func_q   <= s_axis_tuser;
      client_q <= s_axis_tdata[1:0];
      mode_q   <= s_axis_tdata[4:2];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== src/lbps_checker.sv =====
// Port-level checker for the LED blink pattern sequencer, bound to the top level.
`include "assert_macros.svh"

module lbps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lbps_pkg::OutDataW-1:0] m_axis_tdata
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPLIES(a_stat_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[4:3] != 2'd3)
  `ASSERT_IMPLIES(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:5] == 3'd0)
  `ASSERT_IMPLIES(a_stall_full, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)

endmodule

bind led_blink_pattern_sequencer_core lbps_checker u_lbps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== tb/tb.sv =====
// Testbench for led_blink_pattern_sequencer_core: predicts every result beat and checks it.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 8;
  localparam logic [lbps_pkg::ClientW-1:0] CLI_NONE = 2'd3;

  typedef struct packed {
    logic [lbps_pkg::StatW-1:0] stat;
    logic                       sts;
    logic                       net;
    logic                       pwr;
  } leds_t;

  class led_scoreboard;
    int unsigned                period_rom[3][6][2];
    bit                         level_rom[3][6][2];
    int unsigned                step_cnt[3][6];
    int unsigned                mode_cnt[3];
    logic [lbps_pkg::ModeW-1:0] cur_mode[3];
    bit                         cur_phase[3];
    logic [lbps_pkg::TimeW-1:0] ms_left[3];
    leds_t                      leds_q[$];
    int unsigned                errors, ticks, sets, rejects, expiries, beats_out;

    function new();
      for (int c = 0; c < 3; c++) begin
        for (int m = 0; m < 6; m++) put_mode(c, m, 1, 0, 500, 0, 500);
        cur_mode[c]  = '0;
        cur_phase[c] = 1'b0;
        ms_left[c]   = 12'd500;
      end
      mode_cnt = '{3, 6, 3};
      put_mode(0, 1, 1, 1, 500, 1, 500);
      put_mode(0, 2, 2, 1, 500, 0, 2500);
      put_mode(1, 1, 2, 1, 500, 0, 500);
      put_mode(1, 2, 2, 1, 500, 0, 2500);
      put_mode(1, 3, 2, 1, 1000, 0, 2000);
      put_mode(1, 4, 2, 1, 1500, 0, 2500);
      put_mode(1, 5, 1, 1, 1000, 1, 1000);
      put_mode(2, 1, 1, 1, 500, 1, 500);
      put_mode(2, 2, 2, 1, 500, 0, 500);
    endfunction

    function void put_mode(int c, int m, int n, bit l0, int p0, bit l1, int p1);
      step_cnt[c][m]      = n;
      level_rom[c][m][0]  = l0;
      period_rom[c][m][0] = p0;
      level_rom[c][m][1]  = l1;
      period_rom[c][m][1] = p1;
    endfunction

    function void note_input(logic func, logic [lbps_pkg::ClientW-1:0] client,
                             logic [lbps_pkg::ModeW-1:0] mode);
      leds_t r;
      bit    nxt;
      r.stat = lbps_pkg::STAT_OK;
      if (func == lbps_pkg::FUNC_TICK) begin
        ticks++;
        for (int c = 0; c < 3; c++) begin
          if (ms_left[c] <= lbps_pkg::TimeW'(1)) begin
            nxt = !cur_phase[c];
            if (step_cnt[c][cur_mode[c]] < 2) nxt = 1'b0;
            cur_phase[c] = nxt;
            ms_left[c]   = lbps_pkg::TimeW'(period_rom[c][cur_mode[c]][nxt]);
            expiries++;
          end else begin
            ms_left[c] = ms_left[c] - lbps_pkg::TimeW'(1);
          end
        end
      end else begin
        sets++;
        if (client == CLI_NONE) begin
          r.stat = lbps_pkg::STAT_BAD_CLI;
          rejects++;
        end else if (mode >= mode_cnt[client]) begin
          r.stat = lbps_pkg::STAT_BAD_MODE;
          rejects++;
        end else begin
          cur_mode[client]  = mode;
          cur_phase[client] = 1'b0;
          ms_left[client]   = lbps_pkg::TimeW'(period_rom[client][mode][0]);
        end
      end
      r.pwr = level_rom[0][cur_mode[0]][cur_phase[0]];
      r.net = level_rom[1][cur_mode[1]][cur_phase[1]];
      r.sts = level_rom[2][cur_mode[2]][cur_phase[2]];
      leds_q.push_back(r);
    endfunction

    function void check_result(logic [lbps_pkg::OutDataW-1:0] data);
      leds_t got;
      leds_t want;
      got = data[4:0];
      beats_out++;
      if (leds_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", data);
        errors++;
        return;
      end
      want = leds_q.pop_front();
      if (got.pwr !== want.pwr) begin
        $error("led_power: expected %0d, got %0d", want.pwr, got.pwr);
        errors++;
      end
      if (got.net !== want.net) begin
        $error("led_network: expected %0d, got %0d", want.net, got.net);
        errors++;
      end
      if (got.sts !== want.sts) begin
        $error("led_status: expected %0d, got %0d", want.sts, got.sts);
        errors++;
      end
      if (got.stat !== want.stat) begin
        $error("status: expected %0d, got %0d", want.stat, got.stat);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return leds_q.size();
    endfunction
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [lbps_pkg::InDataW-1:0]  s_axis_tdata  = '0;  // client[1:0], mode_sel[4:2]
  logic                          s_axis_tuser  = 1'b0;  // func[0]
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // led_power[0], led_network[1], led_status[2], status[4:3]
  logic [lbps_pkg::OutDataW-1:0] m_axis_tdata;

  logic        gaps_on  = 1'b1;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;

  led_scoreboard sb = new();

  led_blink_pattern_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random backpressure plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(gaps_on && $urandom_range(99) < 17);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic send_beat(input logic func, input logic [lbps_pkg::ClientW-1:0] client,
                           input logic [lbps_pkg::ModeW-1:0] mode);
    while (gaps_on && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(lbps_pkg::InDataW-lbps_pkg::ClientW-lbps_pkg::ModeW){1'b0}},
                      mode, client};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(func, client, mode);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) begin
      send_beat(lbps_pkg::FUNC_TICK, lbps_pkg::ClientW'($urandom_range(3)),
                lbps_pkg::ModeW'($urandom_range(7)));
    end
  endtask

  // mostly legal requests, some with a bad client or mode
  task automatic send_command();
    logic [lbps_pkg::ClientW-1:0] c;
    logic [lbps_pkg::ModeW-1:0]   m;
    if ($urandom_range(99) < 85) begin
      c = lbps_pkg::ClientW'($urandom_range(2));
      m = lbps_pkg::ModeW'($urandom_range(sb.mode_cnt[c] - 1));
    end else begin
      c = lbps_pkg::ClientW'($urandom_range(3));
      m = lbps_pkg::ModeW'($urandom_range(7));
    end
    send_beat(lbps_pkg::FUNC_SET, c, m);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(lbps_pkg::FUNC_TICK, CLI_NONE, 3'd7);
    send_beat(lbps_pkg::FUNC_TICK, lbps_pkg::CLI_POWER, 3'd0);
    for (int m = 0; m < 3; m++) begin
      send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_POWER, lbps_pkg::ModeW'(m));
    end
    for (int m = 0; m < 6; m++) begin
      send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_NETWORK, lbps_pkg::ModeW'(m));
    end
    for (int m = 0; m < 3; m++) begin
      send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_STATUS, lbps_pkg::ModeW'(m));
    end
    send_beat(lbps_pkg::FUNC_SET, CLI_NONE, 3'd0);
    send_beat(lbps_pkg::FUNC_SET, CLI_NONE, 3'd7);
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_POWER, 3'd3);
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_POWER, 3'd7);
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_NETWORK, 3'd6);
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_NETWORK, 3'd7);
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_STATUS, 3'd3);
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_STATUS, 3'd7);
    drain();

    for (int seg = 0; seg < 36; seg++) begin
      if (seg == 6) hold_req <= ~hold_req;
      if (seg == 12 || seg == 24) drain();
      if (seg == 16) gaps_on <= 1'b0;
      if (seg == 22) gaps_on <= 1'b1;
      repeat ($urandom_range(1, 3)) send_command();
      send_ticks($urandom_range(1, 6));
    end

    // one single-step and two two-step patterns, run past the end of the first step
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_POWER, 3'd1);
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_NETWORK, 3'd1);
    send_beat(lbps_pkg::FUNC_SET, lbps_pkg::CLI_STATUS, 3'd2);
    send_ticks(510);

    drain();
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d ticks with %0d step expiries and %0d set requests (%0d rejected).",
             sb.ticks, sb.expiries, sb.sets, sb.rejects);
    $display("Checked %0d result beats, including a %0d-cycle receiver hold-off.",
             sb.beats_out, HoldCycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
